FILE: src/world_to_screen_projection_defines.svh
// Assertion helpers for the file that checks itself.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define WSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsp check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define WSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsp check failed");

`endif

FILE: src/wsp_pkg.sv
package wsp_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int PIXEL_FRAC_BITS = 8;

  // clip coordinate width: product shifted down, three terms plus translation
  localparam int CW = 66 - COORD_FRAC_BITS;
  // magnitude of a clip coordinate
  localparam int RW = CW - 1;
  // quotient bits of the integer division; the top bit flags overflow
  localparam int QB = 34;
  // shifted divisor width
  localparam int DW = CW + QB - 1;
  // signed integer quotient once the overflow cases are removed
  localparam int QSW = 33;
  localparam int DIM_W = 16;
  // dimension scaled to pixel fixed point
  localparam int SB = DIM_W + PIXEL_FRAC_BITS;
  localparam int PRW = QSW + SB + 1;
  localparam int TW = PRW + 2;

  localparam longint W_MIN = ((longint'(1) << COORD_FRAC_BITS) + 999) / 1000;
  localparam longint HALF = (longint'(1) << PIXEL_FRAC_BITS) >> 1;
  localparam longint TERM_CAP = longint'(1) << 40;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [QB-1:0] Q_LIM = QB'(64'd1 << 31);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_DIMS = 3'd6;

  typedef struct packed {
    logic           vis;
    logic           neg;
    logic [RW-1:0]  rem;
    logic [DW-1:0]  d;
    logic [QB-1:0]  q;
    logic [CW-1:0]  den;
    logic [SB-1:0]  s;
    logic [SB-1:0]  hoff;
  } div_lane_t;

  typedef struct packed {
    logic                  vis;
    logic                  cap;
    logic                  cap_neg;
    logic signed [QSW-1:0] q;
    logic [CW-1:0]         r;
    logic [CW-1:0]         den;
    logic [CW-1:0]         rem;
    logic [SB-1:0]         s;
    logic [SB-1:0]         sh;
    logic [SB-1:0]         quo;
    logic [SB-1:0]         hoff;
  } frac_lane_t;

  typedef struct packed {
    logic                  vis;
    logic                  cap;
    logic                  cap_neg;
    logic signed [PRW-1:0] p;
    logic [SB:0]           quo;
    logic [SB-1:0]         hoff;
  } fin_lane_t;

endpackage

FILE: src/wsp_if.sv
interface wsp_point_if;
  import wsp_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface wsp_pixel_if;
  import wsp_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic               visible;
  modport source (output valid, output screen_x, output screen_y, output visible, input ready);
  modport sink (input valid, input screen_x, input screen_y, input visible, output ready);
endinterface

interface wsp_cfg_if;
  import wsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/wsp_div_cell.sv
module wsp_div_cell (
  input  logic               clk,
  input  logic               en,
  input  wsp_pkg::div_lane_t lane_in,
  output wsp_pkg::div_lane_t lane_out
);
  import wsp_pkg::*;

  logic [DW-1:0] rem_ext;
  logic          ge;
  div_lane_t     lane_next;

  // one restoring step: try the shifted divisor against the remainder
  assign rem_ext = DW'(lane_in.rem);
  assign ge = rem_ext >= lane_in.d;

  // form the next lane, shifting the divisor down one place
  always_comb begin
    lane_next = lane_in;
    lane_next.rem = ge ? (lane_in.rem - lane_in.d[RW-1:0]) : lane_in.rem;
    lane_next.q = {lane_in.q[QB-2:0], ge};
    lane_next.d = lane_in.d >> 1;
  end

  // advance the lane
  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

FILE: src/wsp_frac_cell.sv
module wsp_frac_cell (
  input  logic                clk,
  input  logic                en,
  input  wsp_pkg::frac_lane_t lane_in,
  output wsp_pkg::frac_lane_t lane_out
);
  import wsp_pkg::*;

  logic [CW:0]   den_ext;
  logic [CW:0]   r2;
  logic [CW:0]   r2s;
  logic [CW:0]   r3;
  logic [CW:0]   r3s;
  logic          i1;
  logic          i2;
  logic          b;
  logic [SB-1:0] quo_next;
  frac_lane_t    lane_next;

  // double the remainder, then add the fraction when this scale bit is set
  always_comb begin
    den_ext = {1'b0, lane_in.den};
    b = lane_in.sh[SB-1];
    r2 = {lane_in.rem, 1'b0};
    i1 = r2 >= den_ext;
    r2s = i1 ? (r2 - den_ext) : r2;
    r3 = r2s + {1'b0, lane_in.r};
    i2 = b && (r3 >= den_ext);
    r3s = b ? (i2 ? (r3 - den_ext) : r3) : r2s;
    quo_next = {lane_in.quo[SB-2:0], 1'b0} + SB'(i1) + SB'(i2);
    lane_next = lane_in;
    lane_next.rem = r3s[CW-1:0];
    lane_next.quo = quo_next;
    lane_next.sh = lane_in.sh << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_next;
    end
  end

endmodule

FILE: src/wsp_dot.sv
module wsp_dot (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [31:0]         px,
  input  logic signed [31:0]         py,
  input  logic signed [31:0]         pz,
  input  logic [63:0]                pair0,
  input  logic [63:0]                pair1,
  output logic signed [wsp_pkg::CW-1:0] sum
);
  import wsp_pkg::*;

  logic signed [63:0] p0;
  logic signed [63:0] p1;
  logic signed [63:0] p2;

  // register the three coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= $signed(pair0[31:0]) * px;
      p1 <= $signed(pair0[63:32]) * py;
      p2 <= $signed(pair1[31:0]) * pz;
    end
  end

  // floor each product to coordinate precision and add the translation
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= CW'(p0 >>> COORD_FRAC_BITS) + CW'(p1 >>> COORD_FRAC_BITS)
           + CW'(p2 >>> COORD_FRAC_BITS) + CW'($signed(pair1[63:32]));
    end
  end

endmodule

FILE: src/world_to_screen_projection.sv
// Projects world points to pixel positions, one point per clock cycle while
// the output does not stall. Three row units form clip x, y and w, first
// registering the products and then their sum; the floor of the clip coordinate
// over 2w then passes a row of QB = 34 division cells, one quotient bit per
// cell, and the fraction of each ratio times the scaled screen size passes a
// row of SB = 24 cells, one scale bit per cell; a multiply and a saturating
// add end the pipeline. The whole pipeline stalls only while a finished
// result is waiting at the output. Configuration writes are taken in any
// cycle and must only happen while no point is in flight.
`include "world_to_screen_projection_defines.svh"

module world_to_screen_projection (
  input logic         clk,
  input logic         rst,
  wsp_point_if.sink   point,
  wsp_pixel_if.source pixel,
  wsp_cfg_if.sink     cfg
);
  import wsp_pkg::*;

  localparam int NST = QB + SB + 6;

  logic [63:0]          mat [6];
  logic [31:0]          dims;
  logic                 en;
  logic [NST-1:0]       v;
  logic signed [CW-1:0] clip [3];
  logic signed [CW-1:0] sum_w [3];
  logic [DIM_W-1:0]     dim [2];
  div_lane_t            dprep [2];
  div_lane_t            dchain [2][1:QB];
  frac_lane_t           fprep [2];
  frac_lane_t           fchain [2][1:SB];
  fin_lane_t            fin [2];
  logic signed [31:0]   res [2];
  logic                 vis_out;

  assign en = !v[NST-1] || pixel.ready;
  assign point.ready = en;
  assign cfg.ready = 1'b1;
  assign dim[0] = dims[15:0];
  assign dim[1] = dims[31:16];

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) mat[i] <= '0;
      dims <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROW_X_FIRST:  mat[0] <= cfg.data;
        REG_ROW_X_SECOND: mat[1] <= cfg.data;
        REG_ROW_Y_FIRST:  mat[2] <= cfg.data;
        REG_ROW_Y_SECOND: mat[3] <= cfg.data;
        REG_ROW_W_FIRST:  mat[4] <= cfg.data;
        REG_ROW_W_SECOND: mat[5] <= cfg.data;
        REG_SCREEN_DIMS:  dims <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // advance the stage valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], point.valid};
    end
  end

  // clip x, y and w
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_row
      wsp_dot u_dot (
        .clk   (clk),
        .en    (en),
        .px    (point.point_x),
        .py    (point.point_y),
        .pz    (point.point_z),
        .pair0 (mat[2*g]),
        .pair1 (mat[2*g+1]),
        .sum   (sum_w[g])
      );
    end
  endgenerate

  assign clip = sum_w;

  genvar l, j;
  generate
    for (l = 0; l < 2; l++) begin : g_lane
      logic signed [CW-1:0] c;
      logic                 vis;
      logic [CW-1:0]        den;
      logic [RW-1:0]        m;
      logic [QB-1:0]        qu;
      logic                 big;
      logic                 neg;
      div_lane_t            dl;
      frac_lane_t           fl;
      logic                 inc0;
      logic signed [SB:0]   s_ext;
      logic signed [PRW-1:0] p_full;
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] hs;
      logic signed [TW-1:0] r;

      // test w, form the divisor and the magnitude of the clip coordinate, less one when negative
      always_comb begin
        c = clip[l];
        vis = clip[2] >= CW'(W_MIN);
        den = CW'({clip[2], 1'b0});
        m = c[CW-1] ? ~c[RW-1:0] : c[RW-1:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          dprep[l].vis <= vis;
          dprep[l].neg <= c[CW-1];
          dprep[l].rem <= m;
          dprep[l].d <= DW'(den) << (QB - 1);
          dprep[l].q <= '0;
          dprep[l].den <= den;
          dprep[l].s <= SB'(dim[l]) << PIXEL_FRAC_BITS;
          dprep[l].hoff <= SB'(dim[l] >> 1) << PIXEL_FRAC_BITS;
        end
      end

      for (j = 0; j < QB; j++) begin : g_div
        if (j == 0) begin : g_first
          wsp_div_cell u_cell (
            .clk (clk), .en (en), .lane_in (dprep[l]), .lane_out (dchain[l][1])
          );
        end else begin : g_next
          wsp_div_cell u_cell (
            .clk (clk), .en (en), .lane_in (dchain[l][j]), .lane_out (dchain[l][j+1])
          );
        end
      end

      // turn the magnitude quotient into a floored signed quotient and remainder
      always_comb begin
        dl = dchain[l][QB];
        qu = dl.q;
        big = qu[QB-1];
        neg = dl.neg;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          fprep[l].vis <= dl.vis;
          fprep[l].cap <= neg ? (big || (qu >= Q_LIM)) : (big || (qu > Q_LIM));
          fprep[l].cap_neg <= neg;
          fprep[l].q <= neg ? $signed(~qu[QSW-1:0]) : $signed(qu[QSW-1:0]);
          fprep[l].r <= neg ? (dl.den - CW'(1) - CW'(dl.rem)) : CW'(dl.rem);
          fprep[l].den <= dl.den;
          fprep[l].rem <= '0;
          fprep[l].s <= dl.s;
          fprep[l].sh <= dl.s;
          fprep[l].quo <= '0;
          fprep[l].hoff <= dl.hoff;
        end
      end

      for (j = 0; j < SB; j++) begin : g_frac
        if (j == 0) begin : g_first
          wsp_frac_cell u_cell (
            .clk (clk), .en (en), .lane_in (fprep[l]), .lane_out (fchain[l][1])
          );
        end else begin : g_next
          wsp_frac_cell u_cell (
            .clk (clk), .en (en), .lane_in (fchain[l][j]), .lane_out (fchain[l][j+1])
          );
        end
      end

      // scale the integer quotient; round half up when there are no pixel fractions
      always_comb begin
        fl = fchain[l][SB];
        s_ext = $signed({1'b0, fl.s});
        p_full = fl.q * s_ext;
        inc0 = (PIXEL_FRAC_BITS == 0)
            && (({1'b0, fl.rem} + {1'b0, fl.den >> 1}) >= {1'b0, fl.den});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          fin[l].vis <= fl.vis;
          fin[l].cap <= fl.cap;
          fin[l].cap_neg <= fl.cap_neg;
          fin[l].p <= p_full;
          fin[l].quo <= {1'b0, fl.quo} + (SB + 1)'(inc0);
          fin[l].hoff <= fl.hoff;
        end
      end

      // add to the screen center (subtract for y) and saturate
      always_comb begin
        if (fin[l].cap) begin
          t = fin[l].cap_neg ? -TW'(TERM_CAP) : TW'(TERM_CAP);
        end else begin
          t = TW'(fin[l].p) + TW'($signed({1'b0, fin[l].quo})) + TW'(HALF);
        end
        hs = TW'($signed({1'b0, fin[l].hoff}));
        r = (l == 1) ? (hs - t) : (hs + t);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (!fin[l].vis) begin
            res[l] <= '0;
          end else if (r > TW'(S32_MAX)) begin
            res[l] <= 32'sh7fffffff;
          end else if (r < TW'(S32_MIN)) begin
            res[l] <= 32'sh80000000;
          end else begin
            res[l] <= r[31:0];
          end
        end
      end
    end
  endgenerate

  // hold visibility with the results
  always_ff @(posedge clk) begin
    if (en) begin
      vis_out <= fin[0].vis;
    end
  end

  assign pixel.valid = v[NST-1];
  assign pixel.screen_x = res[0];
  assign pixel.screen_y = res[1];
  assign pixel.visible = vis_out;

  `WSP_ASSERT_NOW(a_hidden_zero, pixel.valid && !pixel.visible, pixel.screen_x == 32'sd0 && pixel.screen_y == 32'sd0)
  `WSP_ASSERT_NOW(a_ready_when_empty, !pixel.valid, point.ready)
  `WSP_ASSERT_NEXT(a_request_enters, point.valid && point.ready, v[0])

endmodule
